### rtl/sof_frame_deframer_crc8_crc16_assert.svh
// Assertion macros for the frame deframer, empty in synthesis builds.
`ifndef SOF_FRAME_DEFRAMER_CRC8_CRC16_ASSERT_SVH
`define SOF_FRAME_DEFRAMER_CRC8_CRC16_ASSERT_SVH

`ifndef SYNTHESIS
`define SFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sfd assertion failed");
`define SFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sfd assertion failed");
`else
`define SFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/sfd_pkg.sv
// Shared types, constants and CRC functions of the frame deframer.
package sfd_pkg;

    // register reset values
    localparam logic [7:0]  START_BYTE_RESET = 8'hA5;
    localparam logic [15:0] MAX_FRAME_RESET  = 16'd128;

    // register indexes (address bit 2)
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_MAX_FRAME  = 1'b1;

    // frame layout
    localparam logic [15:0] HDR_BYTES   = 16'd5;
    localparam logic [16:0] OVERHEAD    = 17'd9;
    localparam logic [16:0] BODY_TAIL   = 17'd7; // overhead less the two check bytes
    localparam logic [15:0] CMD_HI_IDX  = 16'd6;
    localparam logic [15:0] PAYLOAD_IDX = 16'd7;

    // CRC settings
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [7:0]  CRC8_POLY  = 8'h8C;  // 0x31 reflected
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'h8408;

    // parser steps
    localparam logic [2:0] STEP_HUNT   = 3'd0;
    localparam logic [2:0] STEP_LEN_LO = 3'd1;
    localparam logic [2:0] STEP_LEN_HI = 3'd2;
    localparam logic [2:0] STEP_SEQ    = 3'd3;
    localparam logic [2:0] STEP_HCRC   = 3'd4;
    localparam logic [2:0] STEP_BODY   = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    // one queued item from parser to output stage
    typedef struct packed {
        logic        verdict;
        logic        good;
        logic [7:0]  data;
        logic [15:0] offset;
        logic [15:0] cmd;
        logic [15:0] len;
        logic [7:0]  seq;
    } sfd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sfd_q_stat_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/sfd_fifo.sv
// Short item queue between the frame parser and the output stage.
`include "sof_frame_deframer_crc8_crc16_assert.svh"

module sfd_fifo #(
    parameter int DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sfd_pkg::sfd_item_t    push_item,
    input  logic                  pop,
    output sfd_pkg::sfd_item_t    head_item,
    output sfd_pkg::sfd_q_stat_t  stat
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sfd_pkg::sfd_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SFD_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !stat.full)
    `SFD_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, pop, !stat.empty)
    `SFD_ASSERT_NXT(a_push_fills, aclk, aresetn, push && !pop, !stat.empty)
    `SFD_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL_CNT)

endmodule

### rtl/sfd_front.sv
// Frame parser: hunts, checks the header CRC8, runs the frame CRC16 and queues results.
module sfd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               byte_fire,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         start_byte,
    input  logic [15:0]        max_frame_bytes,
    output logic               push,
    output sfd_pkg::sfd_item_t push_item
);
    logic [2:0]  step_reg, step_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  hcrc_reg, hcrc_next;
    logic [15:0] fcrc_reg, fcrc_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [7:0]  chk_lo_reg, chk_lo_next;

    logic [7:0]  hcrc_base;
    logic [15:0] fcrc_base;
    logic [7:0]  hcrc_upd;
    logic [15:0] fcrc_upd;
    logic [15:0] len_full;
    logic [16:0] idx17;
    logic [16:0] tail_idx;
    logic        in_data;

    // a start byte reseeds both CRCs
    assign hcrc_base = (step_reg == sfd_pkg::STEP_HUNT) ? sfd_pkg::CRC8_INIT : hcrc_reg;
    assign fcrc_base = (step_reg == sfd_pkg::STEP_HUNT) ? sfd_pkg::CRC16_INIT : fcrc_reg;
    assign hcrc_upd  = sfd_pkg::crc8_byte(hcrc_base, rx_byte);
    assign fcrc_upd  = sfd_pkg::crc16_byte(fcrc_base, rx_byte);

    assign len_full = {rx_byte, len_reg[7:0]};
    assign idx17    = {1'b0, count_reg};
    assign tail_idx = {1'b0, len_reg} + sfd_pkg::BODY_TAIL;   // index of check low byte
    assign in_data  = idx17 < tail_idx;

    always_comb begin
        step_next   = step_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        hcrc_next   = hcrc_reg;
        fcrc_next   = fcrc_reg;
        seq_next    = seq_reg;
        cmd_next    = cmd_reg;
        chk_lo_next = chk_lo_reg;
        push        = 1'b0;
        push_item.verdict = 1'b0;
        push_item.good    = 1'b0;
        push_item.data    = rx_byte;
        push_item.offset  = count_reg - sfd_pkg::PAYLOAD_IDX;
        push_item.cmd     = cmd_reg;
        push_item.len     = len_reg;
        push_item.seq     = seq_reg;
        if (byte_fire) begin
            case (step_reg)
                sfd_pkg::STEP_HUNT: begin
                    if (rx_byte == start_byte) begin
                        hcrc_next  = hcrc_upd;
                        fcrc_next  = fcrc_upd;
                        count_next = 16'd1;
                        step_next  = sfd_pkg::STEP_LEN_LO;
                    end else begin
                        count_next = '0;
                    end
                end
                sfd_pkg::STEP_LEN_LO: begin
                    len_next   = {8'h00, rx_byte};
                    hcrc_next  = hcrc_upd;
                    fcrc_next  = fcrc_upd;
                    count_next = 16'd2;
                    step_next  = sfd_pkg::STEP_LEN_HI;
                end
                sfd_pkg::STEP_LEN_HI: begin
                    len_next   = len_full;
                    hcrc_next  = hcrc_upd;
                    fcrc_next  = fcrc_upd;
                    count_next = 16'd3;
                    if (({1'b0, len_full} + sfd_pkg::OVERHEAD) < {1'b0, max_frame_bytes}) begin
                        step_next = sfd_pkg::STEP_SEQ;
                    end else begin
                        step_next  = sfd_pkg::STEP_HUNT;
                        count_next = '0;
                    end
                end
                sfd_pkg::STEP_SEQ: begin
                    seq_next   = rx_byte;
                    hcrc_next  = hcrc_upd;
                    fcrc_next  = fcrc_upd;
                    count_next = 16'd4;
                    step_next  = sfd_pkg::STEP_HCRC;
                end
                sfd_pkg::STEP_HCRC: begin
                    fcrc_next  = fcrc_upd;
                    count_next = sfd_pkg::HDR_BYTES;
                    if (rx_byte == hcrc_reg) begin
                        step_next = sfd_pkg::STEP_BODY;
                    end else begin
                        step_next  = sfd_pkg::STEP_HUNT;
                        count_next = '0;
                    end
                end
                sfd_pkg::STEP_BODY: begin
                    if (in_data) begin
                        fcrc_next = fcrc_upd;
                    end
                    if (count_reg == sfd_pkg::HDR_BYTES) begin
                        cmd_next = {8'h00, rx_byte};
                    end else if (count_reg == sfd_pkg::CMD_HI_IDX) begin
                        cmd_next = {rx_byte, cmd_reg[7:0]};
                    end else if (in_data) begin
                        push = 1'b1;
                    end else if (idx17 == tail_idx) begin
                        chk_lo_next = rx_byte;
                    end else begin
                        push              = 1'b1;
                        push_item.verdict = 1'b1;
                        push_item.good    = (chk_lo_reg == fcrc_reg[7:0]) &&
                                            (rx_byte == fcrc_reg[15:8]);
                    end
                    count_next = count_reg + 16'd1;
                    if ((idx17 + 17'd1) >= ({1'b0, len_reg} + sfd_pkg::OVERHEAD)) begin
                        step_next  = sfd_pkg::STEP_HUNT;
                        count_next = '0;
                    end
                end
                default: begin
                    step_next  = sfd_pkg::STEP_HUNT;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= sfd_pkg::STEP_HUNT;
            count_reg <= '0;
        end else begin
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        hcrc_reg   <= hcrc_next;
        fcrc_reg   <= fcrc_next;
        seq_reg    <= seq_next;
        cmd_reg    <= cmd_next;
        chk_lo_reg <= chk_lo_next;
    end

endmodule

### rtl/sfd_back.sv
// Output stage: pops queued items, forms the result fields and holds them for the sink.
module sfd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfd_pkg::sfd_item_t   head_item,
    input  sfd_pkg::sfd_q_stat_t stat,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_payload_byte,
    output logic [15:0]          m_payload_offset,
    output logic [15:0]          m_command_word,
    output logic [15:0]          m_frame_length,
    output logic [7:0]           m_sequence_res
);
    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] offset_reg;
    logic [15:0] cmd_reg;
    logic [15:0] len_reg;
    logic [7:0]  seq_reg;
    logic [1:0]  kind_next;

    assign pop = !stat.empty && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
        if (!head_item.verdict) begin
            kind_next = sfd_pkg::KIND_PAYLOAD;
        end else if (head_item.good) begin
            kind_next = sfd_pkg::KIND_GOOD;
        end else begin
            kind_next = sfd_pkg::KIND_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg   <= kind_next;
            byte_reg   <= head_item.verdict ? 8'h00 : head_item.data;
            offset_reg <= head_item.verdict ? 16'h0000 : head_item.offset;
            cmd_reg    <= head_item.cmd;
            len_reg    <= head_item.len;
            seq_reg    <= head_item.seq;
        end
    end

    assign m_valid          = valid_reg;
    assign m_kind           = kind_reg;
    assign m_payload_byte   = byte_reg;
    assign m_payload_offset = offset_reg;
    assign m_command_word   = cmd_reg;
    assign m_frame_length   = len_reg;
    assign m_sequence_res   = seq_reg;

endmodule

### rtl/sof_frame_deframer_crc8_crc16.sv
// Top level of the start-byte frame deframer with header CRC8 and frame CRC16.
//
// Receives one byte per item on the s_ channel and reports on the m_ channel. Frame layout:
// start byte, length (LE 16 bit), sequence byte, header CRC8 (reflected 0x31, init 0xFF, over
// the first four bytes), command id (LE 16 bit), payload, CRC16 (reflected 0x8408, init 0xFFFF,
// no final xor, low byte first, over everything before it). A header whose length + 9 is not
// below max_frame_bytes, or whose CRC8 is wrong, is dropped silently and hunting restarts with
// the next byte. Each payload byte comes out as a tentative item (kind 0) as soon as it
// arrives; after the last check byte one verdict item follows, kind 1 to commit the frame or
// kind 2 to drop it. The parser takes one byte per clock while s_ready is high and updates both
// CRCs in the cycle the byte is taken. A result is written into the queue on the accepting edge
// and then loaded into the output register that drives m_valid. A small queue (QUEUE_DEPTH items)
// decouples the parser from the output register, so s_ready only drops once the queue is full
// behind a stalled sink.
// Registers: start_byte at 0x0 (reset 0xA5), max_frame_bytes at 0x4 (reset 128); write them
// only while the block is idle.
module sof_frame_deframer_crc8_crc16 #(
    parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_offset,
    output logic [15:0] m_command_word,
    output logic [15:0] m_frame_length,
    output logic [7:0]  m_sequence_res,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic        byte_fire;
    logic        push;
    logic        pop;
    logic        cfg_wr;
    logic [7:0]  start_byte_reg, start_byte_next;
    logic [15:0] max_frame_reg, max_frame_next;

    sfd_pkg::sfd_item_t   push_item;
    sfd_pkg::sfd_item_t   head_item;
    sfd_pkg::sfd_q_stat_t q_stat;

    // register port: zero wait states, word index in address bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        start_byte_next = start_byte_reg;
        max_frame_next  = max_frame_reg;
        if (cfg_wr) begin
            case (paddr[2])
                sfd_pkg::REG_START_BYTE: start_byte_next = pwdata[7:0];
                sfd_pkg::REG_MAX_FRAME:  max_frame_next  = pwdata[15:0];
                default: ;
            endcase
        end
        case (paddr[2])
            sfd_pkg::REG_START_BYTE: prdata = {24'h000000, start_byte_reg};
            sfd_pkg::REG_MAX_FRAME:  prdata = {16'h0000, max_frame_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= sfd_pkg::START_BYTE_RESET;
            max_frame_reg  <= sfd_pkg::MAX_FRAME_RESET;
        end else begin
            start_byte_reg <= start_byte_next;
            max_frame_reg  <= max_frame_next;
        end
    end

    // a byte is taken whenever the queue has room for the item it may cause
    assign s_ready   = !q_stat.full;
    assign byte_fire = s_valid && s_ready;

    sfd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_fire       (byte_fire),
        .rx_byte         (s_rx_byte),
        .start_byte      (start_byte_reg),
        .max_frame_bytes (max_frame_reg),
        .push            (push),
        .push_item       (push_item)
    );

    sfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    sfd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_item        (head_item),
        .stat             (q_stat),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_payload_byte   (m_payload_byte),
        .m_payload_offset (m_payload_offset),
        .m_command_word   (m_command_word),
        .m_frame_length   (m_frame_length),
        .m_sequence_res   (m_sequence_res)
    );

endmodule

### verif/tb_sof_frame_deframer_crc8_crc16.sv
// Self-checking bench for the start-byte frame deframer: random framed byte traffic, scoreboard.
module tb_sof_frame_deframer_crc8_crc16;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    localparam int TAIL_CYCLES  = 16;     // output register plus a short queue
    localparam int BLACKOUT_LEN = 300;    // long sink stall, well past the queue depth
    localparam int CYCLE_LIMIT  = 200000;

    // how a generated frame is deliberately shaped
    typedef enum {
        FRAME_CLEAN,
        FRAME_BAD_HDR,
        FRAME_BAD_CRC16,
        FRAME_TOO_LONG
    } frame_shape_t;

    // one result item as the deframer should report it
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] offset;
        logic [15:0] cmd;
        logic [15:0] len;
        logic [7:0]  seq;
    } frame_report_t;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_payload_offset;
    logic [15:0] m_command_word;
    logic [15:0] m_frame_length;
    logic [7:0]  m_sequence_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    sof_frame_deframer_crc8_crc16 u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_payload_byte   (m_payload_byte),
        .m_payload_offset (m_payload_offset),
        .m_command_word   (m_command_word),
        .m_frame_length   (m_frame_length),
        .m_sequence_res   (m_sequence_res),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [7:0]    tx_bytes[$];        // bytes waiting to be offered
    frame_report_t reports_due[$];     // predicted results, oldest first
    int            bytes_pushed = 0;
    int            bytes_taken = 0;
    int            faults = 0;
    int            cycles = 0;

    // handshakes seen at the last rising edge, used by the falling-edge drivers
    logic byte_taken_now = 1'b0;
    logic report_taken_now = 1'b0;

    // idling controls, set per phase by the stimulus
    bit src_gaps_on = 1'b1;
    bit sink_gaps_on = 1'b1;
    bit blackout_go = 1'b0;
    bit sink_blackout = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;

    // register copies, only changed while the block is quiet
    logic [7:0]  cfg_start_byte = sfd_pkg::START_BYTE_RESET;
    logic [15:0] cfg_max_frame = sfd_pkg::MAX_FRAME_RESET;

    // parser copy held by the predictor
    logic [2:0]  rx_step;
    logic [15:0] rx_count;
    logic [15:0] rx_len;
    logic [7:0]  rx_hcrc;
    logic [15:0] rx_fcrc;
    logic [7:0]  rx_seq;
    logic [15:0] rx_cmd;
    logic [7:0]  rx_chk_lo;

    // ------------------------------------------------------------------
    // CRC helpers: reflected, LSB first, one byte at a time
    // ------------------------------------------------------------------
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8) r = (r >> 1) ^ (r[0] ? sfd_pkg::CRC8_POLY : 8'h00);
        return r;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = (r >> 1) ^ (r[0] ? sfd_pkg::CRC16_POLY : 16'h0000);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: advance the parser copy by one accepted byte and queue
    // whatever result that byte produces (payload item or verdict).
    // ------------------------------------------------------------------
    task automatic deframe_byte(input logic [7:0] b);
        logic [16:0]   total;
        logic [16:0]   idx;
        frame_report_t rep;
        total      = sfd_pkg::OVERHEAD + {1'b0, rx_len};
        idx        = {1'b0, rx_count};
        rep        = '0;
        // header fields cannot change on a byte that emits, so latch them now
        rep.cmd    = rx_cmd;
        rep.len    = rx_len;
        rep.seq    = rx_seq;
        case (rx_step)
            sfd_pkg::STEP_HUNT: begin
                if (b == cfg_start_byte) begin
                    rx_hcrc  = crc8_step(sfd_pkg::CRC8_INIT, b);
                    rx_fcrc  = crc16_step(sfd_pkg::CRC16_INIT, b);
                    rx_count = 16'd1;
                    rx_step  = sfd_pkg::STEP_LEN_LO;
                end else begin
                    rx_count = 16'd0;
                end
            end
            sfd_pkg::STEP_LEN_LO: begin
                rx_len   = {8'h00, b};
                rx_hcrc  = crc8_step(rx_hcrc, b);
                rx_fcrc  = crc16_step(rx_fcrc, b);
                rx_count = 16'd2;
                rx_step  = sfd_pkg::STEP_LEN_HI;
            end
            sfd_pkg::STEP_LEN_HI: begin
                rx_len   = {b, rx_len[7:0]};
                rx_hcrc  = crc8_step(rx_hcrc, b);
                rx_fcrc  = crc16_step(rx_fcrc, b);
                rx_count = 16'd3;
                // length check is 17 bits wide so a huge length cannot wrap
                if (sfd_pkg::OVERHEAD + {1'b0, rx_len} < {1'b0, cfg_max_frame}) begin
                    rx_step = sfd_pkg::STEP_SEQ;
                end else begin
                    rx_step  = sfd_pkg::STEP_HUNT;
                    rx_count = 16'd0;
                end
            end
            sfd_pkg::STEP_SEQ: begin
                rx_seq   = b;
                rx_hcrc  = crc8_step(rx_hcrc, b);
                rx_fcrc  = crc16_step(rx_fcrc, b);
                rx_count = 16'd4;
                rx_step  = sfd_pkg::STEP_HCRC;
            end
            sfd_pkg::STEP_HCRC: begin
                rx_fcrc  = crc16_step(rx_fcrc, b);
                rx_count = sfd_pkg::HDR_BYTES;
                if (b == rx_hcrc) begin
                    rx_step = sfd_pkg::STEP_BODY;
                end else begin
                    rx_step  = sfd_pkg::STEP_HUNT;
                    rx_count = 16'd0;
                end
            end
            sfd_pkg::STEP_BODY: begin
                if (idx < total - 17'd2) begin
                    rx_fcrc = crc16_step(rx_fcrc, b);
                end
                if (idx == {1'b0, sfd_pkg::HDR_BYTES}) begin
                    rx_cmd = {8'h00, b};
                end else if (idx == {1'b0, sfd_pkg::CMD_HI_IDX}) begin
                    rx_cmd = {b, rx_cmd[7:0]};
                end else if (idx < total - 17'd2) begin
                    rep.kind   = sfd_pkg::KIND_PAYLOAD;
                    rep.data   = b;
                    rep.offset = idx[15:0] - sfd_pkg::PAYLOAD_IDX;
                    reports_due.push_back(rep);
                end else if (idx == total - 17'd2) begin
                    rx_chk_lo = b;
                end else begin
                    rep.kind = (rx_chk_lo == rx_fcrc[7:0] && b == rx_fcrc[15:8]) ?
                               sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD;
                    reports_due.push_back(rep);
                end
                rx_count = idx[15:0] + 16'd1;
                if (idx + 17'd1 >= total) begin
                    rx_step  = sfd_pkg::STEP_HUNT;
                    rx_count = 16'd0;
                end
            end
            default: begin
                rx_step  = sfd_pkg::STEP_HUNT;
                rx_count = 16'd0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic note_fault(input string msg);
        $display("%0t ns: MISMATCH %s", $realtime, msg);
        faults++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            note_fault($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted byte, score every accepted result.
    // Bytes are predicted first; a result never comes out on the same edge
    // as the byte that caused it, so the order within this block is safe.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : byte_and_report_monitor
        frame_report_t head;
        if (!aresetn) begin
            byte_taken_now   <= 1'b0;
            report_taken_now <= 1'b0;
            rx_step          = sfd_pkg::STEP_HUNT;
            rx_count         = 16'd0;
            rx_len           = 16'd0;
            rx_hcrc          = sfd_pkg::CRC8_INIT;
            rx_fcrc          = sfd_pkg::CRC16_INIT;
            rx_seq           = 8'd0;
            rx_cmd           = 16'd0;
            rx_chk_lo        = 8'd0;
        end else begin
            byte_taken_now   <= s_valid && s_ready;
            report_taken_now <= m_valid && m_ready;
            if (s_valid && s_ready) begin
                deframe_byte(s_rx_byte);
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    note_fault($sformatf("result with nothing due: kind %0d offset %0d",
                                         m_kind, m_payload_offset));
                end else begin
                    head = reports_due.pop_front();
                    check_field("kind", {14'd0, m_kind}, {14'd0, head.kind});
                    check_field("payload_byte", {8'd0, m_payload_byte}, {8'd0, head.data});
                    check_field("payload_offset", m_payload_offset, head.offset);
                    check_field("command_word", m_command_word, head.cmd);
                    check_field("frame_length", m_frame_length, head.len);
                    check_field("sequence_res", {8'd0, m_sequence_res}, {8'd0, head.seq});
                end
            end
        end
    end

    // watchdog: a lost result or a stuck handshake ends here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte source: offers queued bytes, holds each until taken, then waits
    // a drawn number of cycles before the next one.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : byte_source
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else if (s_valid && !byte_taken_now) begin
            // still waiting for s_ready: payload stays put
        end else if (src_gap != 0) begin
            s_valid <= 1'b0;
            src_gap <= src_gap - 1;
        end else if (tx_bytes.size() != 0) begin
            s_valid   <= 1'b1;
            s_rx_byte <= tx_bytes.pop_front();
            src_gap   <= src_gaps_on ? int'($urandom_range(0, 7)) : 0;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: after each taken result it drops m_ready for a drawn
    // number of cycles; the blackout overrides everything.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : result_sink
        int wait_n;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            wait_n = report_taken_now ?
                     (sink_gaps_on ? int'($urandom_range(0, 7)) : 0) : sink_gap;
            if (sink_blackout) begin
                m_ready  <= 1'b0;
                sink_gap <= wait_n;
            end else if (wait_n != 0) begin
                m_ready  <= 1'b0;
                sink_gap <= wait_n - 1;
            end else begin
                m_ready  <= 1'b1;
                sink_gap <= 0;
            end
        end
    end

    // long sink stall, counted here so the source keeps pushing meanwhile
    initial begin : sink_blackout_ctl
        wait (blackout_go);
        @(negedge aclk);
        sink_blackout <= 1'b1;
        repeat (BLACKOUT_LEN) @(negedge aclk);
        sink_blackout <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_pushed++;
    endtask

    // builds one frame with the current start byte; faults cut it short or
    // spoil a check value
    task automatic push_frame(input int len, input logic [15:0] cmd,
                              input frame_shape_t shape);
        logic [7:0]  fb[$];
        logic [7:0]  hc;
        logic [15:0] fc;
        logic [15:0] l16;
        l16 = len[15:0];
        fb.push_back(cfg_start_byte);
        fb.push_back(l16[7:0]);
        fb.push_back(l16[15:8]);
        if (shape != FRAME_TOO_LONG) begin
            fb.push_back(8'($urandom));
            hc = sfd_pkg::CRC8_INIT;
            foreach (fb[i]) hc = crc8_step(hc, fb[i]);
            if (shape == FRAME_BAD_HDR) begin
                hc = hc ^ 8'($urandom_range(1, 255));
            end
            fb.push_back(hc);
            if (shape != FRAME_BAD_HDR) begin
                fb.push_back(cmd[7:0]);
                fb.push_back(cmd[15:8]);
                repeat (len) fb.push_back(8'($urandom));
                fc = sfd_pkg::CRC16_INIT;
                foreach (fb[i]) fc = crc16_step(fc, fb[i]);
                if (shape == FRAME_BAD_CRC16) begin
                    fc = fc ^ (16'd1 << $urandom_range(0, 15));
                end
                fb.push_back(fc[7:0]);
                fb.push_back(fc[15:8]);
            end
        end
        foreach (fb[i]) queue_byte(fb[i]);
    endtask

    // mostly clean frames with random content; the rest spoilt frames,
    // oversize headers and loose noise bytes
    task automatic random_traffic(input int n, input bit with_noise);
        int first;
        int pick;
        int sz;
        int len;
        int lmax;
        int cap;
        @(posedge aclk);
        first = bytes_pushed;
        lmax  = int'(cfg_max_frame) - 10;
        if (lmax < 0) lmax = 0;
        cap = (lmax < 250) ? lmax : 250;
        while (bytes_pushed - first < n) begin
            pick = $urandom_range(0, 99);
            sz   = $urandom_range(0, 99);
            if (sz < 60) begin
                len = $urandom_range(0, (cap < 8) ? cap : 8);
            end else if (sz < 90) begin
                len = $urandom_range(0, (cap < 40) ? cap : 40);
            end else if (sz < 95) begin
                len = $urandom_range(0, cap);
            end else begin
                len = cap;
            end
            if (pick < 70) begin
                push_frame(len, 16'($urandom), FRAME_CLEAN);
            end else if (pick < 80) begin
                push_frame(len, 16'($urandom), FRAME_BAD_CRC16);
            end else if (pick < 87) begin
                push_frame(len, 16'($urandom), FRAME_BAD_HDR);
            end else if (pick < 92 || !with_noise) begin
                push_frame($urandom_range(int'(cfg_max_frame) - 9, 65535),
                           16'($urandom), FRAME_TOO_LONG);
            end else begin
                repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
            end
        end
    endtask

    // wait until every byte is in and every due result is out, then a
    // few more cycles for anything still inside the pipe
    task automatic drain();
        do @(negedge aclk); while (bytes_taken != bytes_pushed || reports_due.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    // leave the parser hunting: pad out any frame that noise opened
    task automatic settle();
        int n;
        drain();
        while (rx_step != sfd_pkg::STEP_HUNT) begin
            n = (rx_step == sfd_pkg::STEP_BODY) ?
                int'(sfd_pkg::OVERHEAD + {1'b0, rx_len}) - int'(rx_count) : 1;
            repeat (n) queue_byte(~cfg_start_byte);
            drain();
        end
    endtask

    // two-phase register write; the mirror follows once the write has landed
    task automatic reg_write(input logic reg_idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (reg_idx == sfd_pkg::REG_START_BYTE) begin
            cfg_start_byte = value[7:0];
        end else begin
            cfg_max_frame = value[15:0];
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // directed, reset registers: empty payload, bad frame CRC, bad header
        // CRC, and a header one past the length limit
        push_frame(0, 16'hFFFF, FRAME_CLEAN);
        push_frame(1, 16'h0000, FRAME_BAD_CRC16);
        push_frame(3, 16'h1234, FRAME_BAD_HDR);
        push_frame(int'(sfd_pkg::MAX_FRAME_RESET) - 9, 16'h0000, FRAME_TOO_LONG);
        settle();

        // reset registers, gaps on both sides, with the long sink stall
        random_traffic(80, 1'b1);
        blackout_go = 1'b1;
        settle();

        // start byte zero, widest limit, full rate; no noise so nothing opens
        // a frame of unbounded length. Includes offsets past 255 and both
        // oversize extremes of the length field.
        reg_write(sfd_pkg::REG_START_BYTE, 32'h0000_0000);
        reg_write(sfd_pkg::REG_MAX_FRAME, 32'h0000_FFFF);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        random_traffic(20, 1'b0);
        push_frame(270, 16'($urandom), FRAME_CLEAN);
        push_frame(65526, 16'($urandom), FRAME_TOO_LONG);
        push_frame(65535, 16'($urandom), FRAME_TOO_LONG);
        settle();

        // smallest limit: no header can pass, so no results at all
        reg_write(sfd_pkg::REG_START_BYTE, 32'h0000_00FF);
        reg_write(sfd_pkg::REG_MAX_FRAME, 32'd9);
        src_gaps_on = 1'b1;
        random_traffic(30, 1'b1);
        settle();

        // limit of ten: only empty payloads pass
        reg_write(sfd_pkg::REG_START_BYTE, 32'($urandom_range(0, 255)));
        reg_write(sfd_pkg::REG_MAX_FRAME, 32'd10);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b1;
        random_traffic(30, 1'b1);
        settle();

        // random registers and idling
        reg_write(sfd_pkg::REG_START_BYTE, 32'($urandom_range(0, 255)));
        reg_write(sfd_pkg::REG_MAX_FRAME, 32'($urandom_range(20, 200)));
        src_gaps_on  = 1'($urandom);
        sink_gaps_on = 1'($urandom);
        random_traffic(50, 1'b1);
        settle();

        if (faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_fifo.sv
rtl/sfd_front.sv
rtl/sfd_back.sv
rtl/sof_frame_deframer_crc8_crc16.sv
verif/tb_sof_frame_deframer_crc8_crc16.sv
